// ----- hdl/dsnc_pkg.sv -----
// package: types, constants and sha-256 helper functions for the nonce checker
`timescale 1ns / 1ps
package dsnc_pkg;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [23:0] COEF_MASK = 24'hffffff;
	localparam logic [31:0] COMPACT_RESET = 32'h1d00ffff;
	localparam logic [4:0] LIMB_BIT_MASK = 5'd31;
	localparam int ROUNDS = 64;

	localparam logic [2:0] REG_MID_LO = 3'd0;
	localparam logic [2:0] REG_MID_MLO = 3'd1;
	localparam logic [2:0] REG_MID_MHI = 3'd2;
	localparam logic [2:0] REG_MID_HI = 3'd3;
	localparam logic [2:0] REG_MERKLE = 3'd4;
	localparam logic [2:0] REG_COMPACT = 3'd5;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] state_t;
	typedef word_t [15:0] sched_t;

	localparam word_t SHA_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam state_t SHA_IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic word_t swap32(input word_t x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one round; st[0]=a .. st[7]=h
	function automatic state_t sha_round(input state_t st, input word_t k, input word_t w);
		word_t t1;
		word_t t2;
		state_t r;
		t1 = st[7] + (rotr(st[4], 6) ^ rotr(st[4], 11) ^ rotr(st[4], 25))
			+ ((st[4] & st[5]) ^ (~st[4] & st[6])) + k + w;
		t2 = (rotr(st[0], 2) ^ rotr(st[0], 13) ^ rotr(st[0], 22))
			+ ((st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]));
		r[7] = st[6];
		r[6] = st[5];
		r[5] = st[4];
		r[4] = st[3] + t1;
		r[3] = st[2];
		r[2] = st[1];
		r[1] = st[0];
		r[0] = t1 + t2;
		return r;
	endfunction

	// shift the 16-word window by one schedule step; w[0] is the word in use
	function automatic sched_t sched_next(input sched_t w);
		word_t s0;
		word_t s1;
		sched_t r;
		s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
		s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
		for (int i = 0; i < 15; i++) r[i] = w[i + 1];
		r[15] = w[0] + s0 + w[9] + s1;
		return r;
	endfunction
endpackage

// ----- hdl/dsnc_compress.sv -----
// pipelined sha-256 compression: one round per stage plus feed-forward stage
`timescale 1ns / 1ps
module dsnc_compress
	import dsnc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  state_t      in_state,
	input  sched_t      in_block,
	input  logic [31:0] in_tag,
	output logic        out_valid,
	output state_t      out_state,
	output logic [31:0] out_tag
);
	logic              vld_s  [ROUNDS+1];
	state_t            wst_s  [ROUNDS+1];
	state_t            init_s [ROUNDS+1];
	sched_t            sch_s  [ROUNDS];
	logic   [31:0]     tag_s  [ROUNDS+1];

	assign vld_s[0]  = in_valid;
	assign wst_s[0]  = in_state;
	assign init_s[0] = in_state;
	assign sch_s[0]  = in_block;
	assign tag_s[0]  = in_tag;

	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[r+1] <= 1'b0;
			else vld_s[r+1] <= vld_s[r];
		end
		always_ff @(posedge clk) begin
			wst_s[r+1]  <= sha_round(wst_s[r], SHA_K[r], sch_s[r][0]);
			init_s[r+1] <= init_s[r];
			tag_s[r+1]  <= tag_s[r];
		end
		if (r < ROUNDS - 1) begin : g_sched
			always_ff @(posedge clk) begin
				sch_s[r+1] <= sched_next(sch_s[r]);
			end
		end
	end

	logic   ff_vld_q;
	state_t ff_st_q;
	logic [31:0] ff_tag_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ff_vld_q <= 1'b0;
		else ff_vld_q <= vld_s[ROUNDS];
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 8; i++) ff_st_q[i] <= init_s[ROUNDS][i] + wst_s[ROUNDS][i];
		ff_tag_q <= tag_s[ROUNDS];
	end

	assign out_valid = ff_vld_q;
	assign out_state = ff_st_q;
	assign out_tag   = ff_tag_q;
endmodule

// ----- hdl/double_sha256_nonce_check.sv -----
// top level: double sha-256 nonce checker with target compare
`timescale 1ns / 1ps
// usage:
//  start with nonce_in launches one candidate; busy is always low, so a nonce
//  may be given on every clock. each beat produces one result beat, shown for
//  one cycle with done high: nonce_out, meets_target and digest_q0..q3.
//  the accepting edge loads the first of 131 register stages, 65 per
//  compression (64 round stages and a feed-forward stage) for two
//  compressions, then a registered compare of the digest with the target,
//  which raises done.
//  throughput is one nonce per clock; the unrolled round pipeline sets this.
//  configuration: cfg_we, cfg_index, cfg_data; write only while idle.
//  writing compact_bits recomputes the 256-bit target in the same edge.
//  reset clears all pipeline valid bits and the configuration registers, and loads
//  compact_bits 0x1d00ffff with its expanded target.
//  the receiver cannot stall; results leave in order, one per done cycle.
module double_sha256_nonce_check
	import dsnc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] nonce_in,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic        done,
	output logic [31:0] nonce_out,
	output logic        meets_target,
	output logic [63:0] digest_q0,
	output logic [63:0] digest_q1,
	output logic [63:0] digest_q2,
	output logic [63:0] digest_q3
);
	logic [63:0]  mid_lo_q, mid_mlo_q, mid_mhi_q, mid_hi_q, merkle_q;
	logic [31:0]  compact_q;
	logic [255:0] target_q;

	function automatic logic [255:0] expand(input logic [31:0] cb);
		logic [7:0]   ex;
		logic [255:0] t;
		ex = cb[31:24];
		t = '0;
		if (ex >= 8'd3 && ex <= 8'd34)
			t = {232'b0, cb[23:0] & COEF_MASK} << {ex - 8'd3, 3'b000};
		return t;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_lo_q  <= '0;
			mid_mlo_q <= '0;
			mid_mhi_q <= '0;
			mid_hi_q  <= '0;
			merkle_q  <= '0;
			compact_q <= COMPACT_RESET;
			target_q  <= expand(COMPACT_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MID_LO:  mid_lo_q  <= cfg_data;
				REG_MID_MLO: mid_mlo_q <= cfg_data;
				REG_MID_MHI: mid_mhi_q <= cfg_data;
				REG_MID_HI:  mid_hi_q  <= cfg_data;
				REG_MERKLE:  merkle_q  <= cfg_data;
				REG_COMPACT: begin
					compact_q <= cfg_data[31:0];
					target_q  <= expand(cfg_data[31:0]);
				end
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	state_t mid_st;
	sched_t blk1;
	assign mid_st = {mid_hi_q[63:32], mid_hi_q[31:0], mid_mhi_q[63:32], mid_mhi_q[31:0],
		mid_mlo_q[63:32], mid_mlo_q[31:0], mid_lo_q[63:32], mid_lo_q[31:0]};
	always_comb begin
		blk1     = '0;
		blk1[0]  = swap32(merkle_q[31:0]);
		blk1[1]  = swap32(merkle_q[63:32]);
		blk1[2]  = swap32(compact_q);
		blk1[3]  = swap32(nonce_in);
		blk1[4]  = {PAD_BYTE, 24'b0};
		blk1[15] = 32'd640;
	end

	logic        h1_vld;
	state_t      h1_st;
	logic [31:0] h1_tag;
	dsnc_compress u_first (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy), .in_state(mid_st),
		.in_block(blk1), .in_tag(nonce_in),
		.out_valid(h1_vld), .out_state(h1_st), .out_tag(h1_tag)
	);

	sched_t blk2;
	always_comb begin
		blk2 = '0;
		for (int i = 0; i < 8; i++) blk2[i] = h1_st[i];
		blk2[8]  = {PAD_BYTE, 24'b0};
		blk2[15] = 32'd256;
	end

	logic        h2_vld;
	state_t      h2_st;
	logic [31:0] h2_tag;
	dsnc_compress u_second (
		.clk(clk), .arst_n(arst_n), .in_valid(h1_vld), .in_state(SHA_IV),
		.in_block(blk2), .in_tag(h1_tag),
		.out_valid(h2_vld), .out_state(h2_st), .out_tag(h2_tag)
	);

	logic [255:0] dig;
	always_comb begin
		for (int i = 0; i < 8; i++) dig[32*i +: 32] = swap32(h2_st[i]);
	end

	logic         done_q;
	logic [31:0]  nonce_q;
	logic         hit_q;
	logic [255:0] dig_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= h2_vld;
	end
	always_ff @(posedge clk) begin
		nonce_q <= h2_tag;
		hit_q   <= (dig <= target_q);
		dig_q   <= dig;
	end

	assign done         = done_q;
	assign nonce_out    = nonce_q;
	assign meets_target = hit_q;
	assign digest_q0    = dig_q[63:0];
	assign digest_q1    = dig_q[127:64];
	assign digest_q2    = dig_q[191:128];
	assign digest_q3    = dig_q[255:192];

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_h2_follows: assert property (@(posedge clk) disable iff (!arst_n) h2_vld |=> done)
		else $error("result beat lost");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(h2_vld))
		else $error("result beat invented");
	a_small_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(compact_q[31:24] < 8'd3) |-> (target_q == '0))
		else $error("small exponent target not zero");
endmodule
